[rtl/bayer_column_sigma_clip_average_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the column sigma-clip average block
// Shared forms for the concurrent checks; clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef BAYER_COLUMN_SIGMA_CLIP_AVERAGE_MACROS_SVH
`define BAYER_COLUMN_SIGMA_CLIP_AVERAGE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define BCSCA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcsca check failed");

// antecedent implies consequent in the next cycle
`define BCSCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcsca check failed");

`endif

[rtl/bcsca_pkg.sv]
// ----------------------------------------------------------------------------
// bcsca_pkg
// Shared constants and helpers for the column sigma-clip average block.
// ----------------------------------------------------------------------------
package bcsca_pkg;

  localparam int unsigned BAND_ROWS_DEF = 80;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned ENT_W         = 25;

  // configuration register indexes
  localparam logic CFG_CLIP_ENABLE    = 1'b0;
  localparam logic CFG_CLIP_THRESHOLD = 1'b1;

  // channel codes
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  function automatic logic [1:0] ch_of(input logic row_odd, input logic col_odd);
    logic [1:0] c;
    if (col_odd && !row_odd) begin
      c = CH_BLUE;
    end else if (!col_odd && row_odd) begin
      c = CH_RED;
    end else begin
      c = CH_GREEN;
    end
    return c;
  endfunction

endpackage

[rtl/bcsca_ram.sv]
// ----------------------------------------------------------------------------
// bcsca_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module bcsca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/bayer_column_sigma_clip_average.sv]
// ----------------------------------------------------------------------------
// bayer_column_sigma_clip_average
// Per-channel sigma-clipped mean of one Bayer column within a row band.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy_o is low and stored in a band RAM;
// a sample that arrives with the band full is dropped and flagged. The word
// with last_in_column_i set raises busy_o and starts the computation: a pass
// over the band for sums and squares, a deviation setup of three products for
// each channel, a rejection pass, and three 40-step divides. All products go
// through one shared byte-serial multiplier (2 to 5 byte steps per product).
// The result is shown for exactly one cycle with done_o high and cannot be
// held off; busy_o falls right after.
// ----------------------------------------------------------------------------
module bayer_column_sigma_clip_average
  import bcsca_pkg::*;
#(
  parameter int unsigned BAND_ROWS = BAND_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [23:0] sample_i,
  input  logic        row_odd_i,
  input  logic        column_odd_i,
  input  logic        last_in_column_i,
  output logic        done_o,
  output logic [31:0] blue_average_o,
  output logic [31:0] green_average_o,
  output logic [31:0] red_average_o,
  output logic [8:0]  blue_kept_o,
  output logic [8:0]  green_kept_o,
  output logic [8:0]  red_kept_o,
  output logic        band_overflow_o
);

  localparam int unsigned AW = $clog2(BAND_ROWS);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_P1_RD    = 14'b00000000000010,
    ST_P1_LD    = 14'b00000000000100,
    ST_P1_MUL   = 14'b00000000001000,
    ST_DV_KICK  = 14'b00000000010000,
    ST_DV_NQ    = 14'b00000000100000,
    ST_DV_SS    = 14'b00000001000000,
    ST_DV_TH    = 14'b00000010000000,
    ST_P2_RD    = 14'b00000100000000,
    ST_P2_LD    = 14'b00001000000000,
    ST_P2_NV    = 14'b00010000000000,
    ST_P2_SQ    = 14'b00100000000000,
    ST_DIV_KICK = 14'b01000000000000,
    ST_DIV      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_q;

  logic              clip_en_q;
  logic [7:0]        clip_thr_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic              ovf_q;
  logic              col_odd_q;
  logic [1:0]        ci_q;
  logic [ENT_W-1:0]  ent_q;
  logic [63:0]       tmp_q;

  logic signed [32:0] sum_q  [3];
  logic [54:0]        sq_q   [3];
  logic [CNT_W-1:0]   cnt_q  [3];
  logic [79:0]        lhs_q  [3];
  logic [CNT_W-1:0]   kept_q [3];
  logic [31:0]        ksum_q [3];
  logic [31:0]        avg_q  [3];

  // shared multiplier
  logic         mul_start;
  logic [63:0]  mul_a, mul_b;
  logic [3:0]   mul_steps;
  logic [63:0]  mul_a_q, mul_b_q;
  logic [127:0] mul_acc_q;
  logic [3:0]   mul_cnt_q;
  logic         mul_done;

  // divider
  logic [39:0] div_quo_q;
  logic [8:0]  div_rem_q;
  logic [8:0]  div_den_q;
  logic [5:0]  div_cnt_q;
  logic [9:0]  div_rem2;

  logic              accept;
  logic [ENT_W-1:0]  rdata;
  logic              ram_we;
  logic signed [23:0] rd_v, ent_v;
  logic [23:0]       rd_abs, ent_abs;
  logic [1:0]        rd_ch, ent_ch;
  logic [32:0]       sum_abs_ci;
  logic [63:0]       dev;
  logic [15:0]       thr2;
  logic signed [34:0] nv, dlt;
  logic [36:0]       m;
  logic              reject;
  logic              last_idx;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE) || out_q;
  assign ram_we = accept && (count_q < CNT_W'(BAND_ROWS));

  bcsca_ram #(
    .WIDTH(ENT_W),
    .DEPTH(BAND_ROWS)
  ) u_band_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({row_odd_i, sample_i}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign rd_v    = signed'(rdata[23:0]);
  assign rd_abs  = rd_v[23] ? 24'(-rd_v) : 24'(rd_v);
  assign rd_ch   = ch_of(rdata[24], col_odd_q);
  assign ent_v   = signed'(ent_q[23:0]);
  assign ent_abs = ent_v[23] ? 24'(-ent_v) : 24'(ent_v);
  assign ent_ch  = ch_of(ent_q[24], col_odd_q);
  assign sum_abs_ci = sum_q[ci_q][32] ? 33'(-sum_q[ci_q]) : 33'(sum_q[ci_q]);
  assign dev     = tmp_q - mul_acc_q[63:0];
  assign thr2    = 16'(clip_thr_q) * 16'(clip_thr_q);
  assign nv      = ent_v[23] ? -signed'({2'b00, mul_acc_q[32:0]})
                             : signed'({2'b00, mul_acc_q[32:0]});
  assign dlt     = nv - 35'(sum_q[ent_ch]);
  assign m       = {(dlt[34] ? 33'(-dlt) : 33'(dlt)), 4'b0000};
  assign reject  = clip_en_q && ({48'd0, lhs_q[ent_ch]} < mul_acc_q);
  assign last_idx = (idx_q == count_q - CNT_W'(1));
  assign mul_done = (mul_cnt_q == 4'd0);
  assign div_rem2 = {div_rem_q, div_quo_q[39]};

  // sequencer
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_steps = 4'd1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_in_column_i) begin
          state_d = ST_P1_RD;
        end
      end
      ST_P1_RD: state_d = ST_P1_LD;
      ST_P1_LD: begin
        mul_start = 1'b1;
        mul_a     = 64'(rd_abs);
        mul_b     = 64'(rd_abs);
        mul_steps = 4'd3;
        state_d   = ST_P1_MUL;
      end
      ST_P1_MUL: begin
        if (mul_done) begin
          state_d = last_idx ? ST_DV_KICK : ST_P1_RD;
        end
      end
      ST_DV_KICK: begin
        mul_start = 1'b1;
        mul_a     = 64'(sq_q[ci_q]);
        mul_b     = 64'(cnt_q[ci_q]);
        mul_steps = 4'd2;
        state_d   = ST_DV_NQ;
      end
      ST_DV_NQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = 64'(sum_abs_ci);
          mul_b     = 64'(sum_abs_ci);
          mul_steps = 4'd5;
          state_d   = ST_DV_SS;
        end
      end
      ST_DV_SS: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = dev;
          mul_b     = 64'(thr2);
          mul_steps = 4'd2;
          state_d   = ST_DV_TH;
        end
      end
      ST_DV_TH: begin
        if (mul_done) begin
          state_d = (ci_q == CH_RED) ? ST_P2_RD : ST_DV_KICK;
        end
      end
      ST_P2_RD: state_d = ST_P2_LD;
      ST_P2_LD: begin
        mul_start = 1'b1;
        mul_a     = 64'(rd_abs);
        mul_b     = 64'(cnt_q[rd_ch]);
        mul_steps = 4'd2;
        state_d   = ST_P2_NV;
      end
      ST_P2_NV: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = 64'(m);
          mul_b     = 64'(m);
          mul_steps = 4'd5;
          state_d   = ST_P2_SQ;
        end
      end
      ST_P2_SQ: begin
        if (mul_done) begin
          state_d = last_idx ? ST_DIV_KICK : ST_P2_RD;
        end
      end
      ST_DIV_KICK: state_d = ST_DIV;
      ST_DIV: begin
        if (div_cnt_q == 6'd0) begin
          state_d = (ci_q == CH_RED) ? ST_IDLE : ST_DIV_KICK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      out_q      <= 1'b0;
      clip_en_q  <= 1'b1;
      clip_thr_q <= 8'd48;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      idx_q      <= '0;
      ci_q       <= CH_BLUE;
      mul_cnt_q  <= '0;
      div_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      out_q   <= (state_q == ST_DIV) && (state_d == ST_IDLE);

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CLIP_ENABLE:    clip_en_q  <= cfg_data_i[0];
          CFG_CLIP_THRESHOLD: clip_thr_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_q) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (accept) begin
        if (ram_we) begin
          count_q <= count_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      // multiplier: MSB byte of b first, accumulator shifts a byte a step
      if (mul_start) begin
        mul_acc_q <= '0;
        mul_a_q   <= mul_a;
        mul_b_q   <= mul_b << {(4'd8 - mul_steps), 3'b000};
        mul_cnt_q <= mul_steps;
      end else if (mul_cnt_q != 4'd0) begin
        mul_acc_q <= {mul_acc_q[119:0], 8'h00}
                   + 128'({8'd0, mul_a_q} * {64'd0, mul_b_q[63:56]});
        mul_b_q   <= {mul_b_q[55:0], 8'h00};
        mul_cnt_q <= mul_cnt_q - 4'd1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept && last_in_column_i) begin
            col_odd_q <= column_odd_i;
            idx_q     <= '0;
            for (int c = 0; c < 3; c++) begin
              sum_q[c]  <= '0;
              sq_q[c]   <= '0;
              cnt_q[c]  <= '0;
              kept_q[c] <= '0;
              ksum_q[c] <= '0;
            end
          end
        end
        ST_P1_LD, ST_P2_LD: ent_q <= rdata;
        ST_P1_MUL: begin
          if (mul_done) begin
            sum_q[ent_ch] <= sum_q[ent_ch] + 33'(ent_v);
            sq_q[ent_ch]  <= sq_q[ent_ch] + mul_acc_q[54:0];
            cnt_q[ent_ch] <= cnt_q[ent_ch] + CNT_W'(1);
            idx_q         <= last_idx ? '0 : idx_q + CNT_W'(1);
            ci_q          <= CH_BLUE;
          end
        end
        ST_DV_NQ: begin
          if (mul_done) begin
            tmp_q <= mul_acc_q[63:0];
          end
        end
        ST_DV_TH: begin
          if (mul_done) begin
            lhs_q[ci_q] <= mul_acc_q[79:0];
            ci_q        <= (ci_q == CH_RED) ? CH_BLUE : ci_q + 2'd1;
          end
        end
        ST_P2_SQ: begin
          if (mul_done) begin
            if (!reject) begin
              kept_q[ent_ch] <= kept_q[ent_ch] + CNT_W'(1);
              if (!ent_v[23] && (ent_v != 24'sd0)) begin
                ksum_q[ent_ch] <= ksum_q[ent_ch] + 32'(ent_abs);
              end
            end
            idx_q <= last_idx ? '0 : idx_q + CNT_W'(1);
          end
        end
        ST_DIV_KICK: begin
          div_quo_q <= {ksum_q[ci_q], 8'h00};
          div_rem_q <= '0;
          div_den_q <= (kept_q[ci_q] == '0) ? 9'd1 : kept_q[ci_q];
          div_cnt_q <= 6'd40;
        end
        ST_DIV: begin
          if (div_cnt_q != 6'd0) begin
            // restoring divide, one quotient bit a cycle
            if (div_rem2 >= {1'b0, div_den_q}) begin
              div_rem_q <= 9'(div_rem2 - {1'b0, div_den_q});
              div_quo_q <= {div_quo_q[38:0], 1'b1};
            end else begin
              div_rem_q <= div_rem2[8:0];
              div_quo_q <= {div_quo_q[38:0], 1'b0};
            end
            div_cnt_q <= div_cnt_q - 6'd1;
          end else begin
            avg_q[ci_q] <= div_quo_q[31:0];
            ci_q        <= (ci_q == CH_RED) ? CH_BLUE : ci_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o          = out_q;
  assign blue_average_o  = avg_q[CH_BLUE];
  assign green_average_o = avg_q[CH_GREEN];
  assign red_average_o   = avg_q[CH_RED];
  assign blue_kept_o     = kept_q[CH_BLUE];
  assign green_kept_o    = kept_q[CH_GREEN];
  assign red_kept_o      = kept_q[CH_RED];
  assign band_overflow_o = ovf_q;

endmodule

[rtl/bcsca_checker.sv]
// ----------------------------------------------------------------------------
// bcsca_checker
// Port-level checks on the command handshake and result strobe.
// ----------------------------------------------------------------------------
`include "bayer_column_sigma_clip_average_macros.svh"

module bcsca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        last_in_column_i,
  input logic        done_o
);

  `BCSCA_ASSERT_SAME(a_done_busy, done_o, busy_o)
  `BCSCA_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy_o)
  `BCSCA_ASSERT_NEXT(a_mid_idle, start_i && !busy_o && !last_in_column_i, !busy_o && !done_o)
  `BCSCA_ASSERT_NEXT(a_last_busy, start_i && !busy_o && last_in_column_i, busy_o && !done_o)

endmodule

bind bayer_column_sigma_clip_average bcsca_checker u_bcsca_checker (.*);
